/* hw/rtl/tea_pkg.sv */
// ----------------------------------------------------------------------------
// TEA cipher package
// Constants, register codes, the stage word and the round mixing function.
// ----------------------------------------------------------------------------
package tea_pkg;

    localparam int MAX_CYCLES  = 32;
    localparam int STAGES      = 2 * MAX_CYCLES;
    localparam int WORD_W      = 32;
    localparam int COUNT_W     = 6;
    localparam int CFG_INDEX_W = 3;

    localparam logic [WORD_W-1:0] TEA_DELTA    = 32'h9E37_79B9;
    localparam logic [WORD_W-1:0] SUM_AFTER_32 = 32'hC6EF_3720;
    localparam logic [WORD_W-1:0] SUM_AFTER_16 = 32'hE377_9B90;

    localparam logic [COUNT_W-1:0] DEC_COUNT_FULL = 6'd32;
    localparam logic [COUNT_W-1:0] DEC_COUNT_HALF = 6'd16;
    localparam logic [COUNT_W-1:0] COUNT_RESET    = 6'd32;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_KEY0   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY1   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY2   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY3   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CYCLES = 3'd4;

    typedef struct packed {
        logic              valid;
        logic              decrypt;
        logic              unsupported;
        logic [WORD_W-1:0] left;
        logic [WORD_W-1:0] right;
    } stage_t;

    function automatic logic [WORD_W-1:0] tea_mix(
        input logic [WORD_W-1:0] w,
        input logic [WORD_W-1:0] sum,
        input logic [WORD_W-1:0] kl,
        input logic [WORD_W-1:0] kr
    );
        return ((w << 4) + kl) ^ (w + sum) ^ ((w >> 5) + kr);
    endfunction

    // m times the round constant, modulo 2^32; elaboration use only
    function automatic logic [WORD_W-1:0] tea_sum(input int m);
        logic [2*WORD_W-1:0] p;
        p = (2*WORD_W)'(m) * (2*WORD_W)'(TEA_DELTA);
        return p[WORD_W-1:0];
    endfunction

endpackage

/* hw/rtl/tea_block_cipher_unit.sv */
// ----------------------------------------------------------------------------
// TEA block cipher unit
// Encrypts or decrypts one 64-bit block per word with a 64-stage round pipeline.
// ----------------------------------------------------------------------------
// Path: a result word is presented once its block word has passed through
//   one input register, then two half-round stages per TEA cycle.
// Throughput: one block per cycle; the whole pipe freezes while the output
//   word waits, and the next block is taken in the same cycle the output goes.
// Reset: aresetn low clears all stage valid bits, the key words to zero and
//   the cycle count to 32.
module tea_block_cipher_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // block input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] left_word, [63:32] right_word
    input  logic [0:0]  s_tuser,   // [0] action (0 encrypt, 1 decrypt)
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] left_result, [63:32] right_result
    output logic [0:0]  m_tuser    // [0] unsupported
);

    // ------------------------------------------------------------------
    // Configuration registers; writes beyond the list are dropped
    // ------------------------------------------------------------------
    logic [tea_pkg::WORD_W-1:0]  key0_reg, key1_reg, key2_reg, key3_reg;
    logic [tea_pkg::COUNT_W-1:0] cycle_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key0_reg        <= '0;
            key1_reg        <= '0;
            key2_reg        <= '0;
            key3_reg        <= '0;
            cycle_count_reg <= tea_pkg::COUNT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                tea_pkg::REG_KEY0:   key0_reg <= cfg_data;
                tea_pkg::REG_KEY1:   key1_reg <= cfg_data;
                tea_pkg::REG_KEY2:   key2_reg <= cfg_data;
                tea_pkg::REG_KEY3:   key3_reg <= cfg_data;
                tea_pkg::REG_CYCLES: cycle_count_reg <= cfg_data[tea_pkg::COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: every stage advances together. Stage 0 takes the
    // input word, stage 2k+1 and 2k+2 hold the two halves of TEA cycle k,
    // the last stage is the output register.
    // ------------------------------------------------------------------
    tea_pkg::stage_t stage_reg  [0:tea_pkg::STAGES];
    tea_pkg::stage_t stage_next [0:tea_pkg::STAGES];
    logic            advance;
    logic            dec_ok;

    assign advance  = !stage_reg[tea_pkg::STAGES].valid || m_tready;
    assign s_tready = advance;

    // Decryption only starts from the precomputed sums for the DEC_COUNT_HALF or
    // DEC_COUNT_FULL count, and only when the pipe is deep enough to hold them.
    assign dec_ok = ((cycle_count_reg == tea_pkg::DEC_COUNT_FULL) ||
                     (cycle_count_reg == tea_pkg::DEC_COUNT_HALF)) &&
                    ({1'b0, cycle_count_reg} <= 7'(tea_pkg::MAX_CYCLES));

    always_comb begin
        stage_next[0].valid       = s_tvalid;
        stage_next[0].decrypt     = s_tuser[0];
        stage_next[0].unsupported = s_tuser[0] && !dec_ok;
        stage_next[0].left        = s_tdata[31:0];
        stage_next[0].right       = s_tdata[63:32];
    end

    // ------------------------------------------------------------------
    // Round stages. A cycle slot is active when its index is below the
    // count and the word is not flagged; this also saturates encryption
    // at the pipe depth and passes flagged words through untouched.
    // ------------------------------------------------------------------
    for (genvar k = 0; k < tea_pkg::MAX_CYCLES; k++) begin : g_cycle
        localparam logic [tea_pkg::WORD_W-1:0] ENC_SUM  = tea_pkg::tea_sum(k + 1);
        localparam logic [tea_pkg::WORD_W-1:0] DEC_FULL =
            tea_pkg::SUM_AFTER_32 - tea_pkg::tea_sum(k);
        localparam logic [tea_pkg::WORD_W-1:0] DEC_HALF =
            tea_pkg::SUM_AFTER_16 - tea_pkg::tea_sum(k);

        logic                       slot_in_count;
        logic                       act_a, act_b;
        logic [tea_pkg::WORD_W-1:0] dec_sum;
        logic [tea_pkg::WORD_W-1:0] sum_a, sum_b;

        assign slot_in_count = {1'b0, 6'(k)} < {1'b0, cycle_count_reg};
        assign dec_sum = (cycle_count_reg == tea_pkg::DEC_COUNT_HALF) ? DEC_HALF : DEC_FULL;

        assign act_a = slot_in_count && !stage_reg[2*k].unsupported;
        assign act_b = slot_in_count && !stage_reg[2*k+1].unsupported;
        assign sum_a = stage_reg[2*k].decrypt   ? dec_sum : ENC_SUM;
        assign sum_b = stage_reg[2*k+1].decrypt ? dec_sum : ENC_SUM;

        // first half: encrypt updates left, decrypt undoes right
        always_comb begin
            stage_next[2*k+1] = stage_reg[2*k];
            if (act_a) begin
                if (stage_reg[2*k].decrypt) begin
                    stage_next[2*k+1].right = stage_reg[2*k].right -
                        tea_pkg::tea_mix(stage_reg[2*k].left, sum_a, key2_reg, key3_reg);
                end else begin
                    stage_next[2*k+1].left = stage_reg[2*k].left +
                        tea_pkg::tea_mix(stage_reg[2*k].right, sum_a, key0_reg, key1_reg);
                end
            end
        end

        // second half: encrypt updates right, decrypt undoes left
        always_comb begin
            stage_next[2*k+2] = stage_reg[2*k+1];
            if (act_b) begin
                if (stage_reg[2*k+1].decrypt) begin
                    stage_next[2*k+2].left = stage_reg[2*k+1].left -
                        tea_pkg::tea_mix(stage_reg[2*k+1].right, sum_b, key0_reg, key1_reg);
                end else begin
                    stage_next[2*k+2].right = stage_reg[2*k+1].right +
                        tea_pkg::tea_mix(stage_reg[2*k+1].left, sum_b, key2_reg, key3_reg);
                end
            end
        end
    end

    // Hold every stage while the output word waits; reset clears valid bits
    always_ff @(posedge aclk) begin
        for (int j = 0; j <= tea_pkg::STAGES; j++) begin
            if (!aresetn) begin
                stage_reg[j].valid <= 1'b0;
            end else if (advance) begin
                stage_reg[j] <= stage_next[j];
            end
        end
    end

    assign m_tvalid   = stage_reg[tea_pkg::STAGES].valid;
    assign m_tdata    = {stage_reg[tea_pkg::STAGES].right, stage_reg[tea_pkg::STAGES].left};
    assign m_tuser[0] = stage_reg[tea_pkg::STAGES].unsupported;

endmodule

/* hw/rtl/tea_checker.sv */
// ----------------------------------------------------------------------------
// TEA cipher port checker
// Watches the top-level ports for stalls, reset and back-pressure behaviour.
// ----------------------------------------------------------------------------
module tea_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        cfg_ready,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    // input is taken exactly when the output register can move
    a_ready_link: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output space");

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word present after reset");

    // configuration writes are never refused
    a_cfg_open: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("configuration channel stalled");

endmodule

bind tea_block_cipher_unit tea_checker u_tea_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_ready (cfg_ready),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
);
